FILE: rtl/stream_pattern_patcher_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the stream pattern patcher
// Same-cycle and next-cycle implication checks, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef STREAM_PATTERN_PATCHER_MACROS_SVH
`define STREAM_PATTERN_PATCHER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SPP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spp: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spp: next-cycle check failed");

`endif

FILE: rtl/spp_pkg.sv
// ---------------------------------------------------------------------------
// spp_pkg
// Constants, types and register codes shared by the pattern patcher modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spp_pkg;

    localparam int MAX_LEN     = 8;
    // pattern register holds eight bytes, so the window never exceeds that
    localparam int WIN_LEN     = (MAX_LEN < 8) ? MAX_LEN : 8;
    localparam int BYTE_W      = 8;
    localparam int REG_W       = 64;
    localparam int LEN_W       = 4;
    localparam int CNT_W       = $clog2(WIN_LEN + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LEN   = 2'd0,
        REG_PATTERN_BYTES = 2'd1,
        REG_PATCH_LEN     = 2'd2,
        REG_PATCH_BYTES   = 2'd3
    } cfg_idx_t;

    // window bytes, oldest in element 0
    typedef logic [WIN_LEN-1:0][BYTE_W-1:0] win_t;

    // one request from the front: an optional leading byte and a flush burst
    typedef struct packed {
        logic              has_head;
        logic [BYTE_W-1:0] head_byte;
        logic              head_last;
        logic [CNT_W-1:0]  flush_cnt;
        win_t              flush_bytes;
        logic              any_patched;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

FILE: rtl/stream_pattern_patcher.sv
// ---------------------------------------------------------------------------
// stream_pattern_patcher
// Streaming byte pattern search and replace over a sliding window.
// ---------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   -------------------------------------
//  input     push / full             data_byte[7:0], stream_end
//  result    empty / pop             out_byte[7:0], last_out, any_patched
//  config    cfg_write (no wait)     cfg_index[1:0], cfg_data[63:0]
//
//  One byte is accepted per cycle while full is low; the window compare and
//  patch finish in the cycle of acceptance. Results pass through the request
//  queue and the output register. A stream_end byte gives a burst of up to 9
//  results, drained one per cycle by the back sequencer while pop keeps up;
//  the 4-entry request queue raises full while bursts back up. Reset clears
//  control state only; no clearing pass is needed. Stalls on pop leave
//  results in the output register; input keeps flowing until the queue fills.
//
`timescale 1ns / 1ps

module stream_pattern_patcher (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [spp_pkg::BYTE_W-1:0]        data_byte,
    input  logic                              stream_end,
    output logic                              empty,
    input  logic                              pop,
    output logic [spp_pkg::BYTE_W-1:0]        out_byte,
    output logic                              last_out,
    output logic                              any_patched,
    input  logic                              cfg_write,
    input  logic [spp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spp_pkg::REG_W-1:0]         cfg_data
);

    logic             in_accept;
    logic             cmd_push;
    logic             q_pop;
    spp_pkg::cmd_t    cmd;
    spp_pkg::cmd_t    q_head;
    spp_pkg::q_stat_t q_stat;

    assign full      = q_stat.full;
    assign in_accept = push && !q_stat.full;

    // classifier and window
    spp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_accept  (in_accept),
        .data_byte  (data_byte),
        .stream_end (stream_end),
        .cmd_push   (cmd_push),
        .cmd        (cmd)
    );

    // request queue
    spp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    // result sequencer
    spp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_head      (q_head),
        .q_stat      (q_stat),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .last_out    (last_out),
        .any_patched (any_patched)
    );

endmodule

FILE: rtl/spp_front.sv
// ---------------------------------------------------------------------------
// spp_front
// Holds configuration and the match window; classifies each accepted byte
// into a request of zero, one or a burst of output bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stream_pattern_patcher_macros.svh"

module spp_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [spp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spp_pkg::REG_W-1:0]         cfg_data,
    input  logic                              in_accept,
    input  logic [spp_pkg::BYTE_W-1:0]        data_byte,
    input  logic                              stream_end,
    output logic                              cmd_push,
    output spp_pkg::cmd_t                     cmd
);

    logic [spp_pkg::LEN_W-1:0] pattern_len_reg;
    logic [spp_pkg::REG_W-1:0] pattern_bytes_reg;
    logic [spp_pkg::LEN_W-1:0] patch_len_reg;
    logic [spp_pkg::REG_W-1:0] patch_bytes_reg;

    spp_pkg::win_t             win_reg, win_next;
    logic [spp_pkg::CNT_W-1:0] fill_reg, fill_next;
    logic [spp_pkg::CNT_W-1:0] skip_reg, skip_next;
    logic                      patched_reg, patched_next;

    logic [spp_pkg::CNT_W-1:0] len_eff, patch_eff, fc, fc1, fc2, sk, sk2;
    logic                      full_win, mismatch, match, flag_new;
    spp_pkg::win_t             w1, w2, w3;

    // effective lengths
    always_comb
    begin
        if (pattern_len_reg > spp_pkg::LEN_W'(spp_pkg::WIN_LEN))
            len_eff = spp_pkg::CNT_W'(spp_pkg::WIN_LEN);
        else
            len_eff = spp_pkg::CNT_W'(pattern_len_reg);
        if (spp_pkg::LEN_W'(patch_len_reg) > spp_pkg::LEN_W'(len_eff))
            patch_eff = len_eff;
        else
            patch_eff = spp_pkg::CNT_W'(patch_len_reg);
    end

    // window shift, insert, compare and patch
    always_comb
    begin
        fc       = (fill_reg > len_eff) ? len_eff : fill_reg;
        full_win = (fc == len_eff);
        w1       = full_win ? (win_reg >> spp_pkg::BYTE_W) : win_reg;
        fc1      = full_win ? (len_eff - spp_pkg::CNT_W'(1)) : fc;
        for (int i = 0; i < spp_pkg::WIN_LEN; i++)
        begin
            w2[i] = (spp_pkg::CNT_W'(i) == fc1) ? data_byte : w1[i];
        end
        fc2 = fc1 + spp_pkg::CNT_W'(1);
        sk  = (skip_reg != '0) ? (skip_reg - spp_pkg::CNT_W'(1)) : '0;

        mismatch = 1'b0;
        for (int i = 0; i < spp_pkg::WIN_LEN; i++)
        begin
            if ((spp_pkg::CNT_W'(i) < len_eff) &&
                (w2[i] != pattern_bytes_reg[spp_pkg::BYTE_W*i +: spp_pkg::BYTE_W]))
                mismatch = 1'b1;
        end
        match = !mismatch && (fc2 == len_eff) && (sk == '0);

        for (int i = 0; i < spp_pkg::WIN_LEN; i++)
        begin
            if (match && (spp_pkg::CNT_W'(i) < len_eff))
                w3[i] = (spp_pkg::CNT_W'(i) < patch_eff) ?
                        patch_bytes_reg[spp_pkg::BYTE_W*i +: spp_pkg::BYTE_W] : '0;
            else
                w3[i] = w2[i];
        end
        flag_new = patched_reg | match;
        sk2      = match ? len_eff : sk;
    end

    // request build and next state
    always_comb
    begin
        win_next     = win_reg;
        fill_next    = fill_reg;
        skip_next    = skip_reg;
        patched_next = patched_reg;
        cmd          = '0;
        if (len_eff == '0)
        begin
            // matching off: straight pass-through
            cmd.has_head    = 1'b1;
            cmd.head_byte   = data_byte;
            cmd.head_last   = stream_end;
            cmd.flush_cnt   = '0;
            cmd.flush_bytes = win_reg;
            cmd.any_patched = patched_reg;
            if (in_accept && stream_end)
                patched_next = 1'b0;
        end
        else
        begin
            cmd.has_head    = full_win;
            cmd.head_byte   = win_reg[0];
            cmd.head_last   = 1'b0;
            cmd.flush_cnt   = stream_end ? fc2 : '0;
            cmd.flush_bytes = w3;
            cmd.any_patched = flag_new;
            if (in_accept)
            begin
                win_next     = w3;
                fill_next    = stream_end ? '0 : fc2;
                skip_next    = stream_end ? '0 : sk2;
                patched_next = stream_end ? 1'b0 : flag_new;
            end
        end
        // a pattern length write drops the buffered window
        if (cfg_write && (cfg_index == spp_pkg::REG_PATTERN_LEN))
        begin
            fill_next = '0;
            skip_next = '0;
        end
        cmd_push = in_accept && (cmd.has_head || (cmd.flush_cnt != '0));
    end

    // configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg   <= '0;
            pattern_bytes_reg <= '0;
            patch_len_reg     <= '0;
            patch_bytes_reg   <= '0;
            fill_reg          <= '0;
            skip_reg          <= '0;
            patched_reg       <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            skip_reg    <= skip_next;
            patched_reg <= patched_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    spp_pkg::REG_PATTERN_LEN:
                        pattern_len_reg <= cfg_data[spp_pkg::LEN_W-1:0];
                    spp_pkg::REG_PATTERN_BYTES: pattern_bytes_reg <= cfg_data;
                    spp_pkg::REG_PATCH_LEN:
                        patch_len_reg <= cfg_data[spp_pkg::LEN_W-1:0];
                    spp_pkg::REG_PATCH_BYTES:   patch_bytes_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // window bytes: only filled positions are ever read
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    `SPP_ASSERT_SAME(a_skip_bound, clk, rst_n, 1'b1, skip_reg <= spp_pkg::CNT_W'(spp_pkg::WIN_LEN))
    `SPP_ASSERT_NEXT(a_end_clears_flag, clk, rst_n, in_accept && stream_end, !patched_reg)

endmodule

FILE: rtl/spp_queue.sv
// ---------------------------------------------------------------------------
// spp_queue
// Short request queue between the front classifier and the back sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stream_pattern_patcher_macros.svh"

module spp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  spp_pkg::cmd_t     push_cmd,
    input  logic              pop,
    output spp_pkg::cmd_t     head,
    output spp_pkg::q_stat_t  stat
);

    spp_pkg::cmd_t              slot_reg [spp_pkg::QUEUE_DEPTH];
    logic [spp_pkg::PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [spp_pkg::PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [spp_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_push, do_pop;

    // pointer and fill control
    always_comb
    begin
        stat.empty  = (count_reg == '0);
        stat.full   = (count_reg == spp_pkg::QCNT_W'(spp_pkg::QUEUE_DEPTH));
        do_push     = push && !stat.full;
        do_pop      = pop && !stat.empty;
        wr_ptr_next = do_push ? (wr_ptr_reg + spp_pkg::PTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + spp_pkg::PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + spp_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - spp_pkg::QCNT_W'(1);
        head = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // request storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    `SPP_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= spp_pkg::QCNT_W'(spp_pkg::QUEUE_DEPTH))
    `SPP_ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop && !stat.full, count_reg == $past(count_reg) + spp_pkg::QCNT_W'(1))

endmodule

FILE: rtl/spp_back.sv
// ---------------------------------------------------------------------------
// spp_back
// Unrolls queued requests into single result bytes through the output
// register, one byte per cycle while the output is not stalled by pop.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stream_pattern_patcher_macros.svh"

module spp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  spp_pkg::cmd_t               q_head,
    input  spp_pkg::q_stat_t            q_stat,
    output logic                        q_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [spp_pkg::BYTE_W-1:0]  out_byte,
    output logic                        last_out,
    output logic                        any_patched
);

    logic                       out_valid_reg, out_valid_next;
    logic [spp_pkg::BYTE_W-1:0] out_byte_reg;
    logic                       last_out_reg;
    logic                       any_patched_reg;
    logic                       head_done_reg, head_done_next;
    logic [spp_pkg::CNT_W-1:0]  pos_reg, pos_next;

    logic                       load, emit, is_head, last_flush, is_last;
    logic [spp_pkg::BYTE_W-1:0] flush_sel, res_byte;
    logic                       res_last;

    // select the current element of the head request
    always_comb
    begin
        flush_sel = '0;
        for (int i = 0; i < spp_pkg::WIN_LEN; i++)
        begin
            if (spp_pkg::CNT_W'(i) == pos_reg)
                flush_sel = q_head.flush_bytes[i];
        end
        is_head    = q_head.has_head && !head_done_reg;
        last_flush = (spp_pkg::CNT_W'(pos_reg + spp_pkg::CNT_W'(1)) == q_head.flush_cnt);
        is_last    = is_head ? (q_head.flush_cnt == '0) : last_flush;
        res_byte   = is_head ? q_head.head_byte : flush_sel;
        res_last   = is_head ? q_head.head_last : last_flush;

        load  = !out_valid_reg || pop;
        emit  = load && !q_stat.empty;
        q_pop = emit && is_last;

        out_valid_next = load ? !q_stat.empty : out_valid_reg;
        head_done_next = head_done_reg;
        pos_next       = pos_reg;
        if (emit)
        begin
            if (is_last)
            begin
                head_done_next = 1'b0;
                pos_next       = '0;
            end
            else if (is_head)
                head_done_next = 1'b1;
            else
                pos_next = pos_reg + spp_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            head_done_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            head_done_reg <= head_done_next;
            pos_reg       <= pos_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg    <= res_byte;
            last_out_reg    <= res_last;
            any_patched_reg <= q_head.any_patched;
        end
    end

    assign empty       = !out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_out    = last_out_reg;
    assign any_patched = any_patched_reg;

    `SPP_ASSERT_NEXT(a_pop_rewinds, clk, rst_n, q_pop, (pos_reg == '0) && !head_done_reg)
    `SPP_ASSERT_SAME(a_pos_in_burst, clk, rst_n, !q_stat.empty && (pos_reg != '0), pos_reg < q_head.flush_cnt)

endmodule
